/* sv/cslt_pkg.sv */
package cslt_pkg;

  // Fixed field widths of the result item
  localparam int KIND_W  = 5;
  localparam int VALUE_W = 64;
  localparam int LINE_W  = 20;
  localparam int KW_NUM  = 6;

  // Token kinds as seen on the result channel
  typedef enum logic [KIND_W-1:0] {
    K_INT     = 5'd0,
    K_IF      = 5'd1,
    K_ELSE    = 5'd2,
    K_WHILE   = 5'd3,
    K_RETURN  = 5'd4,
    K_PRINTF  = 5'd5,
    K_IDENT   = 5'd6,
    K_NUM     = 5'd7,
    K_STR     = 5'd8,
    K_LPAREN  = 5'd9,
    K_RPAREN  = 5'd10,
    K_LBRACE  = 5'd11,
    K_RBRACE  = 5'd12,
    K_SEMI    = 5'd13,
    K_COMMA   = 5'd14,
    K_ASSIGN  = 5'd15,
    K_PLUS    = 5'd16,
    K_MINUS   = 5'd17,
    K_STAR    = 5'd18,
    K_SLASH   = 5'd19,
    K_EQ      = 5'd20,
    K_NE      = 5'd21,
    K_LT      = 5'd22,
    K_GT      = 5'd23,
    K_LE      = 5'd24,
    K_GE      = 5'd25,
    K_END     = 5'd26,
    K_IDCHAR  = 5'd27,
    K_STRCHAR = 5'd28,
    K_ERROR   = 5'd29
  } kind_e;

  // Lexer modes, one-hot
  typedef enum logic [13:0] {
    M_IDLE      = 14'b00000000000001,
    M_SLASH     = 14'b00000000000010,
    M_LINECOM   = 14'b00000000000100,
    M_BLOCK     = 14'b00000000001000,
    M_BLOCKSTAR = 14'b00000000010000,
    M_IDENT     = 14'b00000000100000,
    M_NUMBER    = 14'b00000001000000,
    M_STRING    = 14'b00000010000000,
    M_STRESC    = 14'b00000100000000,
    M_EQUAL     = 14'b00001000000000,
    M_BANG      = 14'b00010000000000,
    M_LESS      = 14'b00100000000000,
    M_GREATER   = 14'b01000000000000,
    M_HALT      = 14'b10000000000000
  } mode_e;

  // One result item
  typedef struct packed {
    kind_e              kind;
    logic [VALUE_W-1:0] value;
    logic [LINE_W-1:0]  line;
    logic               last;
  } res_t;

  // Results of one input item, up to two
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } step_t;

  // Character codes
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_GREAT  = 8'h3E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F});
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b inside {[8'h30:8'h39]});
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b inside {CH_SPACE, [CH_TAB:CH_CR]});
  endfunction

  // Keyword lengths
  function automatic logic [2:0] kw_len(input logic [2:0] k);
    logic [2:0] len;
    case (k)
      3'd0:    len = 3'd3;
      3'd1:    len = 3'd2;
      3'd2:    len = 3'd4;
      3'd3:    len = 3'd5;
      3'd4:    len = 3'd6;
      3'd5:    len = 3'd6;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // Keyword text, first character in the highest used byte
  function automatic logic [63:0] kw_word(input logic [2:0] k);
    logic [63:0] word;
    case (k)
      3'd0:    word = 64'("int");
      3'd1:    word = 64'("if");
      3'd2:    word = 64'("else");
      3'd3:    word = 64'("while");
      3'd4:    word = 64'("return");
      3'd5:    word = 64'("printf");
      default: word = '0;
    endcase
    return word;
  endfunction

  // Drop keyword candidates that do not match letter b at position len
  function automatic logic [KW_NUM-1:0] kw_filter(input logic [KW_NUM-1:0] cand,
                                                 input logic [2:0] len,
                                                 input logic [7:0] b);
    logic [KW_NUM-1:0] keep;
    logic [63:0]       word;
    logic [2:0]        klen;
    logic [2:0]        pos;
    keep = cand;
    for (int k = 0; k < KW_NUM; k++) begin
      klen = kw_len(3'(k));
      word = kw_word(3'(k));
      pos  = klen - len - 3'd1;
      if (len >= klen || word[{pos, 3'b000} +: 8] != b) keep[k] = 1'b0;
    end
    return keep;
  endfunction

  // Kind of a finished identifier
  function automatic kind_e kw_kind(input logic [KW_NUM-1:0] cand, input logic [2:0] len);
    kind_e kind;
    kind = K_IDENT;
    for (int k = 0; k < KW_NUM; k++) begin
      if (cand[k] && len == kw_len(3'(k))) kind = kind_e'(KIND_W'(k));
    end
    return kind;
  endfunction

  function automatic res_t mk_res(input kind_e kind, input logic [VALUE_W-1:0] value,
                                  input logic [LINE_W-1:0] line);
    res_t r;
    r.kind  = kind;
    r.value = value;
    r.line  = line;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

/* sv/cslt_core.sv */
module cslt_core #(
  parameter int LINE_BITS = 20
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           take_i,
  input  logic [7:0]     byte_i,
  input  logic           eoi_i,
  output cslt_pkg::step_t step_o
);
  import cslt_pkg::*;

  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

  mode_e               mode_q, mode_d;
  logic [KW_NUM-1:0]   cand_q, cand_d;
  logic [2:0]          len_q, len_d;
  logic [VALUE_W-1:0]  acc_q, acc_d;
  logic [LINE_BITS-1:0] line_q, line_d;

  logic [LINE_BITS-1:0] line_inc;
  logic [LINE_W-1:0]    line_out;
  logic [VALUE_W-1:0]   acc_next;
  logic [VALUE_W-1:0]   byte_val;
  logic [VALUE_W-1:0]   digit_val;
  logic [7:0]           esc_char;

  res_t       res_a [2];
  logic [1:0] cnt;
  logic       do_idle;
  logic       do_ident;
  logic [KW_NUM-1:0] cand_b;
  logic [2:0]        len_b;

  assign line_inc  = (line_q != LINE_MAX) ? line_q + LINE_ONE : line_q;
  assign line_out  = LINE_W'(line_q);
  assign byte_val  = VALUE_W'(byte_i);
  assign digit_val = VALUE_W'(byte_i - CH_ZERO);
  // acc * 10 + digit as two shifted adds
  assign acc_next  = (acc_q << 3) + (acc_q << 1) + digit_val;

  // Decode escape character
  always_comb begin
    case (byte_i)
      CH_N:    esc_char = CH_NL;
      CH_T:    esc_char = CH_TAB;
      CH_ZERO: esc_char = CH_NUL;
      default: esc_char = byte_i;
    endcase
  end

  // One step of the lexer for the registered item
  always_comb begin
    mode_d   = mode_q;
    cand_d   = cand_q;
    len_d    = len_q;
    acc_d    = acc_q;
    line_d   = line_q;
    cnt      = 2'd0;
    res_a[0] = mk_res(K_END, '0, line_out);
    res_a[1] = mk_res(K_END, '0, line_out);
    do_idle  = 1'b0;
    do_ident = 1'b0;
    cand_b   = cand_q;
    len_b    = len_q;

    if (mode_q != M_HALT) begin
      if (eoi_i) begin
        // Flush the pending token
        case (mode_q)
          M_SLASH: begin
            res_a[cnt[0]] = mk_res(K_SLASH, '0, line_out); cnt = cnt + 2'd1;
          end
          M_IDENT: begin
            res_a[cnt[0]] = mk_res(kw_kind(cand_q, len_q), '0, line_out); cnt = cnt + 2'd1;
          end
          M_NUMBER: begin
            res_a[cnt[0]] = mk_res(K_NUM, acc_q, line_out); cnt = cnt + 2'd1;
          end
          M_STRING, M_STRESC: begin
            res_a[cnt[0]] = mk_res(K_STR, '0, line_out); cnt = cnt + 2'd1;
          end
          M_EQUAL: begin
            res_a[cnt[0]] = mk_res(K_ASSIGN, '0, line_out); cnt = cnt + 2'd1;
          end
          M_BANG: begin
            res_a[cnt[0]] = mk_res(K_ERROR, VALUE_W'(CH_BANG), line_out); cnt = cnt + 2'd1;
            mode_d = M_HALT;
          end
          M_LESS: begin
            res_a[cnt[0]] = mk_res(K_LT, '0, line_out); cnt = cnt + 2'd1;
          end
          M_GREATER: begin
            res_a[cnt[0]] = mk_res(K_GT, '0, line_out); cnt = cnt + 2'd1;
          end
          default: begin
          end
        endcase
        // End token, then back to reset values
        if (mode_q != M_BANG) begin
          res_a[cnt[0]] = mk_res(K_END, '0, line_out); cnt = cnt + 2'd1;
          mode_d = M_IDLE;
          cand_d = '0;
          len_d  = '0;
          acc_d  = '0;
          line_d = LINE_ONE;
        end
      end else begin
        case (mode_q)
          M_SLASH: begin
            if (byte_i == CH_SLASH) mode_d = M_LINECOM;
            else if (byte_i == CH_STAR) mode_d = M_BLOCK;
            else begin
              res_a[cnt[0]] = mk_res(K_SLASH, '0, line_out); cnt = cnt + 2'd1;
              do_idle = 1'b1;
            end
          end
          M_LINECOM: begin
            if (byte_i == CH_NL) begin
              line_d = line_inc;
              mode_d = M_IDLE;
            end
          end
          M_BLOCK: begin
            if (byte_i == CH_STAR) mode_d = M_BLOCKSTAR;
            else if (byte_i == CH_NL) line_d = line_inc;
          end
          M_BLOCKSTAR: begin
            if (byte_i == CH_SLASH) mode_d = M_IDLE;
            else if (byte_i != CH_STAR) begin
              if (byte_i == CH_NL) line_d = line_inc;
              mode_d = M_BLOCK;
            end
          end
          M_IDENT: begin
            if (is_alpha(byte_i) || is_digit(byte_i)) do_ident = 1'b1;
            else begin
              res_a[cnt[0]] = mk_res(kw_kind(cand_q, len_q), '0, line_out); cnt = cnt + 2'd1;
              cand_d  = '0;
              len_d   = '0;
              do_idle = 1'b1;
            end
          end
          M_NUMBER: begin
            if (is_digit(byte_i)) acc_d = acc_next;
            else begin
              res_a[cnt[0]] = mk_res(K_NUM, acc_q, line_out); cnt = cnt + 2'd1;
              acc_d   = '0;
              do_idle = 1'b1;
            end
          end
          M_STRING: begin
            if (byte_i == CH_QUOTE) begin
              res_a[cnt[0]] = mk_res(K_STR, '0, line_out); cnt = cnt + 2'd1;
              mode_d = M_IDLE;
            end else if (byte_i == CH_BSLASH) mode_d = M_STRESC;
            else begin
              res_a[cnt[0]] = mk_res(K_STRCHAR, byte_val, line_out); cnt = cnt + 2'd1;
            end
          end
          M_STRESC: begin
            res_a[cnt[0]] = mk_res(K_STRCHAR, VALUE_W'(esc_char), line_out); cnt = cnt + 2'd1;
            mode_d = M_STRING;
          end
          M_EQUAL: begin
            if (byte_i == CH_EQUAL) begin
              res_a[cnt[0]] = mk_res(K_EQ, '0, line_out); cnt = cnt + 2'd1;
              mode_d = M_IDLE;
            end else begin
              res_a[cnt[0]] = mk_res(K_ASSIGN, '0, line_out); cnt = cnt + 2'd1;
              do_idle = 1'b1;
            end
          end
          M_BANG: begin
            if (byte_i == CH_EQUAL) begin
              res_a[cnt[0]] = mk_res(K_NE, '0, line_out); cnt = cnt + 2'd1;
              mode_d = M_IDLE;
            end else begin
              res_a[cnt[0]] = mk_res(K_ERROR, VALUE_W'(CH_BANG), line_out); cnt = cnt + 2'd1;
              mode_d = M_HALT;
            end
          end
          M_LESS: begin
            if (byte_i == CH_EQUAL) begin
              res_a[cnt[0]] = mk_res(K_LE, '0, line_out); cnt = cnt + 2'd1;
              mode_d = M_IDLE;
            end else begin
              res_a[cnt[0]] = mk_res(K_LT, '0, line_out); cnt = cnt + 2'd1;
              do_idle = 1'b1;
            end
          end
          M_GREATER: begin
            if (byte_i == CH_EQUAL) begin
              res_a[cnt[0]] = mk_res(K_GE, '0, line_out); cnt = cnt + 2'd1;
              mode_d = M_IDLE;
            end else begin
              res_a[cnt[0]] = mk_res(K_GT, '0, line_out); cnt = cnt + 2'd1;
              do_idle = 1'b1;
            end
          end
          default: do_idle = 1'b1;
        endcase

        // Start of a new token from idle
        if (do_idle) begin
          mode_d = M_IDLE;
          if (byte_i == CH_NL) line_d = line_inc;
          else if (is_space(byte_i)) begin
          end else if (is_alpha(byte_i)) begin
            mode_d   = M_IDENT;
            cand_b   = '1;
            len_b    = '0;
            do_ident = 1'b1;
          end else if (is_digit(byte_i)) begin
            mode_d = M_NUMBER;
            acc_d  = digit_val;
          end else begin
            case (byte_i)
              CH_SLASH: mode_d = M_SLASH;
              CH_QUOTE: mode_d = M_STRING;
              CH_EQUAL: mode_d = M_EQUAL;
              CH_BANG:  mode_d = M_BANG;
              CH_LESS:  mode_d = M_LESS;
              CH_GREAT: mode_d = M_GREATER;
              CH_LPAREN: begin
                res_a[cnt[0]] = mk_res(K_LPAREN, '0, line_out); cnt = cnt + 2'd1;
              end
              CH_RPAREN: begin
                res_a[cnt[0]] = mk_res(K_RPAREN, '0, line_out); cnt = cnt + 2'd1;
              end
              CH_LBRACE: begin
                res_a[cnt[0]] = mk_res(K_LBRACE, '0, line_out); cnt = cnt + 2'd1;
              end
              CH_RBRACE: begin
                res_a[cnt[0]] = mk_res(K_RBRACE, '0, line_out); cnt = cnt + 2'd1;
              end
              CH_SEMI: begin
                res_a[cnt[0]] = mk_res(K_SEMI, '0, line_out); cnt = cnt + 2'd1;
              end
              CH_COMMA: begin
                res_a[cnt[0]] = mk_res(K_COMMA, '0, line_out); cnt = cnt + 2'd1;
              end
              CH_PLUS: begin
                res_a[cnt[0]] = mk_res(K_PLUS, '0, line_out); cnt = cnt + 2'd1;
              end
              CH_MINUS: begin
                res_a[cnt[0]] = mk_res(K_MINUS, '0, line_out); cnt = cnt + 2'd1;
              end
              CH_STAR: begin
                res_a[cnt[0]] = mk_res(K_STAR, '0, line_out); cnt = cnt + 2'd1;
              end
              default: begin
                res_a[cnt[0]] = mk_res(K_ERROR, byte_val, line_out); cnt = cnt + 2'd1;
                mode_d = M_HALT;
              end
            endcase
          end
        end

        // Add a letter to the identifier and narrow the keyword candidates
        if (do_ident) begin
          res_a[cnt[0]] = mk_res(K_IDCHAR, byte_val, line_out); cnt = cnt + 2'd1;
          cand_d = kw_filter(cand_b, len_b, byte_i);
          len_d  = (len_b != 3'd7) ? len_b + 3'd1 : len_b;
        end
      end
    end
  end

  // Mark the last result of the item
  always_comb begin
    step_o.count   = cnt;
    step_o.r0      = res_a[0];
    step_o.r0.last = (cnt == 2'd1);
    step_o.r1      = res_a[1];
    step_o.r1.last = 1'b1;
  end

  // Lexer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      cand_q <= '0;
      len_q  <= '0;
      acc_q  <= '0;
      line_q <= LINE_ONE;
    end else if (take_i) begin
      mode_q <= mode_d;
      cand_q <= cand_d;
      len_q  <= len_d;
      acc_q  <= acc_d;
      line_q <= line_d;
    end
  end

endmodule

/* sv/cslt_out.sv */
module cslt_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  cslt_pkg::step_t step_i,
  output logic            free_o,
  output logic            valid_o,
  input  logic            ready_i,
  output cslt_pkg::res_t  head_o
);
  import cslt_pkg::*;

  res_t head_q, tail_q;
  logic head_v_q, tail_v_q;
  logic pop;

  assign pop     = head_v_q & ready_i;
  assign free_o  = !head_v_q || (pop && !tail_v_q);
  assign valid_o = head_v_q;
  assign head_o  = head_q;

  // Slot occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      tail_v_q <= 1'b0;
    end else if (load_i) begin
      head_v_q <= (step_i.count != 2'd0);
      tail_v_q <= (step_i.count == 2'd2);
    end else if (pop) begin
      head_v_q <= tail_v_q;
      tail_v_q <= 1'b0;
    end
  end

  // Load both results, advance the second into the head on a pop
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      head_q <= step_i.r0;
      tail_q <= step_i.r1;
    end else if (pop) begin
      head_q <= tail_q;
    end
  end

endmodule

/* sv/c_subset_byte_tokenizer_top.sv */
// Channel | Dir | tdata (low bit up)                       | tuser       | tlast
// s_axis  | in  | source_byte[7:0]                         | -           | end_of_input
// m_axis  | out | token_value[63:0], line_number[83:64],   | token_kind  | last_of_run
//         |     | zero pad [87:84]                         |             |
//
// An item is held in the input register, is lexed combinationally and its
// results land in a two-slot result register. A new item is taken only once the
// result register is free, so one with two results holds up the next item.
// rst_ni clears the lexer to idle with line 1 and empties both stages.
// A stall on m_axis fills the result register, then the input register, then
// drops s_axis_tready_o.
module c_subset_byte_tokenizer_top #(
  parameter int LINE_BITS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // source_byte[7:0]
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [87:0] m_axis_tdata_o,   // token_value[63:0], line_number[83:64], zero[87:84]
  output logic [4:0]  m_axis_tuser_o,   // token_kind[4:0]
  output logic        m_axis_tlast_o
);
  import cslt_pkg::*;

  logic       in_v_q;
  logic [7:0] in_byte_q;
  logic       in_eoi_q;
  logic       take;
  logic       out_free;
  step_t      step;
  res_t       head;

  assign take            = in_v_q & out_free;
  assign s_axis_tready_o = !in_v_q || take;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_v_q <= 1'b1;
    end else if (take) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_eoi_q  <= s_axis_tlast_i;
    end
  end

  cslt_core #(
    .LINE_BITS(LINE_BITS)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .take_i(take),
    .byte_i(in_byte_q),
    .eoi_i (in_eoi_q),
    .step_o(step)
  );

  cslt_out u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (take),
    .step_i (step),
    .free_o (out_free),
    .valid_o(m_axis_tvalid_o),
    .ready_i(m_axis_tready_i),
    .head_o (head)
  );

  // Pack the result item
  assign m_axis_tdata_o = {4'b0000, head.line, head.value};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.last;

endmodule

/* sv/cslt_checker.sv */
module cslt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [87:0] out_data_i,
  input logic [4:0]  out_user_i,
  input logic        out_last_i
);
  import cslt_pkg::*;

  // Hold a stalled item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i)
      && $stable(out_user_i) && $stable(out_last_i))
    else $error("result item changed while stalled");

  // End and error tokens close their run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_user_i == K_END || out_user_i == K_ERROR) |-> out_last_i)
    else $error("end or error token not last of run");

  // Tokens without payload carry zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_user_i != K_NUM && out_user_i != K_IDCHAR
      && out_user_i != K_STRCHAR && out_user_i != K_ERROR |-> out_data_i[63:0] == '0)
    else $error("nonzero value on a token without payload");

  // Character payloads fit in a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_user_i == K_IDCHAR || out_user_i == K_STRCHAR
      || out_user_i == K_ERROR) |-> out_data_i[63:8] == '0)
    else $error("character payload wider than a byte");

  // Kind stays in the defined range and pad bits stay clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_user_i <= K_ERROR && out_data_i[87:84] == 4'b0000)
    else $error("bad kind code or pad bits");

endmodule

bind c_subset_byte_tokenizer_top cslt_checker u_cslt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(m_axis_tvalid_o),
  .out_ready_i(m_axis_tready_i),
  .out_data_i (m_axis_tdata_o),
  .out_user_i (m_axis_tuser_o),
  .out_last_i (m_axis_tlast_o)
);

/* tb/sv/c_subset_byte_tokenizer_checker.sv */
module c_subset_byte_tokenizer_checker #(
  parameter int LINE_BITS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // source_byte[7:0]
  input  logic        s_axis_tlast_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [87:0] m_axis_tdata_i,   // token_value[63:0], line_number[83:64], zero[87:84]
  input  logic [4:0]  m_axis_tuser_i,   // token_kind[4:0]
  input  logic        m_axis_tlast_i,
  output int          mismatches_o,
  output int          tokens_due_o
);
  import cslt_pkg::*;

  // Lexer state, kept apart from the block
  mode_e                lex_mode;
  logic [KW_NUM-1:0]    kw_cand;
  logic [2:0]           id_len;
  logic [63:0]          num_acc;
  logic [LINE_BITS-1:0] line_cnt;

  // Tokens predicted but not yet seen on the result channel, oldest first
  res_t tokens_due [$];

  string kw_text [KW_NUM] = '{"int", "if", "else", "while", "return", "printf"};

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == 8'h5F;
  endfunction

  function automatic logic is_num(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  task automatic clear_lexer();
    lex_mode = M_IDLE;
    kw_cand  = '0;
    id_len   = '0;
    num_acc  = '0;
    line_cnt = LINE_BITS'(1);
  endtask

  task automatic put_token(input kind_e kind, input logic [63:0] value);
    res_t r;
    r.kind  = kind;
    r.value = value;
    r.line  = LINE_W'(line_cnt);
    r.last  = 1'b0;
    tokens_due.insert(tokens_due.size(), r);
  endtask

  // Saturate the line count at its top value
  task automatic bump_line();
    if (line_cnt != {LINE_BITS{1'b1}}) line_cnt++;
  endtask

  task automatic halt_on(input logic [7:0] b);
    put_token(K_ERROR, 64'(b));
    lex_mode = M_HALT;
  endtask

  // Emit the letter and drop keywords that no longer match
  task automatic ident_push(input logic [7:0] b);
    put_token(K_IDCHAR, 64'(b));
    for (int k = 0; k < KW_NUM; k++) begin
      if (kw_cand[k] && (id_len >= kw_text[k].len() || kw_text[k][id_len] != b))
        kw_cand[k] = 1'b0;
    end
    if (id_len < 3'd7) id_len++;
  endtask

  task automatic close_ident();
    kind_e kind;
    kind = K_IDENT;
    for (int k = 0; k < KW_NUM; k++) begin
      if (kw_cand[k] && id_len == kw_text[k].len()) kind = kind_e'(KIND_W'(k));
    end
    put_token(kind, '0);
    kw_cand  = '0;
    id_len   = '0;
    lex_mode = M_IDLE;
  endtask

  // Byte seen with no token open
  task automatic start_byte(input logic [7:0] b);
    lex_mode = M_IDLE;
    if (b == CH_NL) begin
      bump_line();
    end else if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
      // skip white space
    end else if (is_letter(b)) begin
      lex_mode = M_IDENT;
      kw_cand  = '1;
      id_len   = '0;
      ident_push(b);
    end else if (is_num(b)) begin
      lex_mode = M_NUMBER;
      num_acc  = 64'(b - CH_ZERO);
    end else begin
      case (b)
        CH_SLASH:  lex_mode = M_SLASH;
        CH_QUOTE:  lex_mode = M_STRING;
        CH_EQUAL:  lex_mode = M_EQUAL;
        CH_BANG:   lex_mode = M_BANG;
        CH_LESS:   lex_mode = M_LESS;
        CH_GREAT:  lex_mode = M_GREATER;
        CH_LPAREN: put_token(K_LPAREN, '0);
        CH_RPAREN: put_token(K_RPAREN, '0);
        CH_LBRACE: put_token(K_LBRACE, '0);
        CH_RBRACE: put_token(K_RBRACE, '0);
        CH_SEMI:   put_token(K_SEMI, '0);
        CH_COMMA:  put_token(K_COMMA, '0);
        CH_PLUS:   put_token(K_PLUS, '0);
        CH_MINUS:  put_token(K_MINUS, '0);
        CH_STAR:   put_token(K_STAR, '0);
        default:   halt_on(b);
      endcase
    end
  endtask

  // Work out the tokens that one accepted item causes
  task automatic lex_item(input logic [7:0] b, input logic eoi);
    int         mark;
    res_t       tail;
    logic [7:0] ch;
    mark = tokens_due.size();
    if (lex_mode != M_HALT) begin
      if (eoi) begin
        // flush the open token, then end the stream
        case (lex_mode)
          M_SLASH:            put_token(K_SLASH, '0);
          M_IDENT:            close_ident();
          M_NUMBER:           put_token(K_NUM, num_acc);
          M_STRING, M_STRESC: put_token(K_STR, '0);
          M_EQUAL:            put_token(K_ASSIGN, '0);
          M_BANG:             halt_on(CH_BANG);
          M_LESS:             put_token(K_LT, '0);
          M_GREATER:          put_token(K_GT, '0);
          default:            ;
        endcase
        if (lex_mode != M_HALT) begin
          put_token(K_END, '0);
          clear_lexer();
        end
      end else begin
        case (lex_mode)
          M_SLASH: begin
            if (b == CH_SLASH) lex_mode = M_LINECOM;
            else if (b == CH_STAR) lex_mode = M_BLOCK;
            else begin
              put_token(K_SLASH, '0);
              start_byte(b);
            end
          end
          M_LINECOM: begin
            if (b == CH_NL) begin
              bump_line();
              lex_mode = M_IDLE;
            end
          end
          M_BLOCK: begin
            if (b == CH_STAR) lex_mode = M_BLOCKSTAR;
            else if (b == CH_NL) bump_line();
          end
          M_BLOCKSTAR: begin
            if (b == CH_SLASH) lex_mode = M_IDLE;
            else if (b != CH_STAR) begin
              if (b == CH_NL) bump_line();
              lex_mode = M_BLOCK;
            end
          end
          M_IDENT: begin
            if (is_letter(b) || is_num(b)) ident_push(b);
            else begin
              close_ident();
              start_byte(b);
            end
          end
          M_NUMBER: begin
            if (is_num(b)) num_acc = num_acc * 64'd10 + 64'(b - CH_ZERO);
            else begin
              put_token(K_NUM, num_acc);
              num_acc = '0;
              start_byte(b);
            end
          end
          M_STRING: begin
            if (b == CH_QUOTE) begin
              put_token(K_STR, '0);
              lex_mode = M_IDLE;
            end else if (b == CH_BSLASH) lex_mode = M_STRESC;
            else put_token(K_STRCHAR, 64'(b));
          end
          M_STRESC: begin
            // decode the escape, unknown ones stand for themselves
            if (b == CH_N) ch = CH_NL;
            else if (b == CH_T) ch = CH_TAB;
            else if (b == CH_ZERO) ch = CH_NUL;
            else ch = b;
            put_token(K_STRCHAR, 64'(ch));
            lex_mode = M_STRING;
          end
          M_EQUAL: begin
            if (b == CH_EQUAL) begin
              put_token(K_EQ, '0);
              lex_mode = M_IDLE;
            end else begin
              put_token(K_ASSIGN, '0);
              start_byte(b);
            end
          end
          M_BANG: begin
            if (b == CH_EQUAL) begin
              put_token(K_NE, '0);
              lex_mode = M_IDLE;
            end else halt_on(CH_BANG);
          end
          M_LESS: begin
            if (b == CH_EQUAL) begin
              put_token(K_LE, '0);
              lex_mode = M_IDLE;
            end else begin
              put_token(K_LT, '0);
              start_byte(b);
            end
          end
          M_GREATER: begin
            if (b == CH_EQUAL) begin
              put_token(K_GE, '0);
              lex_mode = M_IDLE;
            end else begin
              put_token(K_GT, '0);
              start_byte(b);
            end
          end
          default: start_byte(b);
        endcase
      end
    end
    // mark the final token of this item
    if (tokens_due.size() > mark) begin
      tail      = tokens_due[tokens_due.size() - 1];
      tail.last = 1'b1;
      tokens_due[tokens_due.size() - 1] = tail;
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches_o++;
      if (mismatches_o <= 100)
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  // Predict on input, compare on output
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      clear_lexer();
      tokens_due.delete();
      tokens_due_o <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) lex_item(s_axis_tdata_i, s_axis_tlast_i);
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (tokens_due.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 100)
            $display("%0t: token with none due: kind %0d value %0h line %0d last %b",
                     $time, m_axis_tuser_i, m_axis_tdata_i[63:0], m_axis_tdata_i[83:64],
                     m_axis_tlast_i);
        end else begin
          want = tokens_due.pop_front();
          check_field("token_kind", 64'(want.kind), 64'(m_axis_tuser_i));
          check_field("token_value", want.value, m_axis_tdata_i[63:0]);
          check_field("line_number", 64'(want.line), 64'(m_axis_tdata_i[83:64]));
          check_field("last_of_run", 64'(want.last), 64'(m_axis_tlast_i));
        end
      end
      tokens_due_o <= tokens_due.size();
    end
  end

endmodule

/* tb/sv/c_subset_byte_tokenizer_top_test.sv */
module c_subset_byte_tokenizer_top_test;
  import cslt_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 1100;

  logic        clk;
  logic        rst_n;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [87:0] m_tdata;
  logic [4:0]  m_tuser;
  logic        m_tlast;

  int mismatches;
  int due_count;
  int src_idle;
  int dst_stall;
  int fed;
  int quiet;

  string kw_list [6] = '{"int", "if", "else", "while", "return", "printf"};

  c_subset_byte_tokenizer_top #(.LINE_BITS(20)) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  c_subset_byte_tokenizer_checker #(.LINE_BITS(20)) tok_chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .m_axis_tlast_i  (m_tlast),
    .mismatches_o    (mismatches),
    .tokens_due_o    (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stall the result channel at the rate of the current phase
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= dst_stall);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet == STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Offer one item after a random gap, hold it until taken
  task automatic feed(input logic [7:0] b, input logic eoi);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eoi;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    fed++;
  endtask

  task automatic feed_text(input string s);
    for (int i = 0; i < s.len(); i++) feed(s[i], 1'b0);
  endtask

  // Letter, underscore or (past the first place) digit
  function automatic logic [7:0] id_char(input bit lead);
    int r;
    r = $urandom_range(lead ? 52 : 62);
    if (r < 26) return 8'(8'h61 + r);
    if (r < 52) return 8'(8'h41 + r - 26);
    if (r == 52) return 8'h5F;
    return 8'(CH_ZERO + r - 53);
  endfunction

  task automatic feed_ident();
    int n;
    n = $urandom_range(1, 10);
    feed(id_char(1'b1), 1'b0);
    repeat (n - 1) feed(id_char(1'b0), 1'b0);
  endtask

  // Digit runs past 19 places wrap the value
  task automatic feed_number();
    int n;
    n = ($urandom_range(5) == 0) ? $urandom_range(18, 26) : $urandom_range(1, 6);
    repeat (n) feed(8'(CH_ZERO + $urandom_range(9)), 1'b0);
  endtask

  // Keyword, sometimes cut short or extended by a letter, digit or underscore
  task automatic feed_keyword();
    string w;
    int    m;
    w = kw_list[$urandom_range(5)];
    m = $urandom_range(3);
    if (m == 1) w = w.substr(0, w.len() - 2);
    feed_text(w);
    if (m == 2) feed(id_char(1'b0), 1'b0);
  endtask

  task automatic feed_string(input bit closed);
    int         n;
    logic [7:0] c;
    feed(CH_QUOTE, 1'b0);
    n = $urandom_range(0, 8);
    repeat (n) begin
      case ($urandom_range(9))
        0: begin
          feed(CH_BSLASH, 1'b0);
          case ($urandom_range(3))
            0:       feed(CH_N, 1'b0);
            1:       feed(CH_T, 1'b0);
            2:       feed(CH_ZERO, 1'b0);
            default: feed(8'($urandom), 1'b0);
          endcase
        end
        1, 2: begin
          do c = 8'($urandom); while (c == CH_QUOTE || c == CH_BSLASH);
          feed(c, 1'b0);
        end
        default: begin
          c = 8'($urandom_range(8'h20, 8'h7E));
          if (c == CH_QUOTE || c == CH_BSLASH) c = CH_SPACE;
          feed(c, 1'b0);
        end
      endcase
    end
    if (closed) feed(CH_QUOTE, 1'b0);
    else if ($urandom_range(1)) feed(CH_BSLASH, 1'b0);
  endtask

  // Block comment body never holds a slash, so it cannot close early
  task automatic feed_block_comment(input bit closed);
    int         n;
    logic [7:0] c;
    feed_text("/*");
    n = $urandom_range(0, 10);
    repeat (n) begin
      case ($urandom_range(5))
        0, 1:    feed(CH_STAR, 1'b0);
        2:       feed(CH_NL, 1'b0);
        default: begin
          do c = 8'($urandom); while (c == CH_SLASH);
          feed(c, 1'b0);
        end
      endcase
    end
    if (closed) begin
      if ($urandom_range(1)) feed(CH_STAR, 1'b0);
      feed_text("*/");
    end else if ($urandom_range(1)) feed(CH_STAR, 1'b0);
  endtask

  task automatic feed_line_comment(input bit closed);
    int         n;
    logic [7:0] c;
    feed_text("//");
    n = $urandom_range(0, 10);
    repeat (n) begin
      do c = 8'($urandom); while (c == CH_NL);
      feed(c, 1'b0);
    end
    if (closed) feed(CH_NL, 1'b0);
  endtask

  // One well-formed token, a comment or a piece of white space
  task automatic feed_token();
    string      ops;
    string      cmp [7] = '{"=", "==", "!=", "<", "<=", ">", ">="};
    logic [7:0] ws [6] = '{CH_SPACE, CH_TAB, CH_NL, CH_CR, 8'h0B, 8'h0C};
    ops = "(){};,+-*";
    case ($urandom_range(13))
      0, 1:    feed_keyword();
      2, 3:    feed_ident();
      4:       feed_number();
      5:       feed_string(1'b1);
      6:       feed_line_comment(1'b1);
      7:       feed_block_comment(1'b1);
      8, 9:    feed(ops[$urandom_range(8)], 1'b0);
      10:      feed_text(cmp[$urandom_range(6)]);
      11: begin
        // keep a lone slash from opening a comment
        feed(CH_SLASH, 1'b0);
        feed(ws[$urandom_range(5)], 1'b0);
      end
      default: feed(ws[$urandom_range(5)], 1'b0);
    endcase
  endtask

  // A run of tokens, maybe a token left open, then end of input
  task automatic feed_stream();
    int n;
    n = $urandom_range(1, 30);
    repeat (n) feed_token();
    case ($urandom_range(11))
      0:       feed_string(1'b0);
      1:       feed_block_comment(1'b0);
      2:       feed_line_comment(1'b0);
      3:       feed(CH_SLASH, 1'b0);
      4:       feed(CH_EQUAL, 1'b0);
      5:       feed(CH_LESS, 1'b0);
      6:       feed(CH_GREAT, 1'b0);
      7:       feed_ident();
      8:       feed_number();
      default: ;
    endcase
    feed(8'($urandom), 1'b1);
  endtask

  initial begin
    int         base;
    int         phase_idle [4] = '{0, 87, 0, 11};
    int         phase_stall [4] = '{0, 0, 87, 11};
    logic [7:0] b;
    rst_n     = 1'b0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    src_idle  = 0;
    dst_stall = 0;
    fed       = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // String with NUL, top byte, unknown and known escapes
    feed(CH_QUOTE, 1'b0);
    feed(CH_NUL, 1'b0);
    feed(8'hFF, 1'b0);
    feed(CH_BSLASH, 1'b0);
    feed("q", 1'b0);
    feed(CH_BSLASH, 1'b0);
    feed(CH_N, 1'b0);
    feed(CH_QUOTE, 1'b0);
    // keyword, not-equal, number cut by a line comment
    feed_text("if!=9//");
    feed(8'hFF, 1'b0);
    feed(CH_NL, 1'b0);
    // open string with a dangling backslash at end of input
    feed(CH_QUOTE, 1'b0);
    feed(CH_BSLASH, 1'b0);
    feed(8'hFF, 1'b1);

    // Random streams over the idle and stall phases
    base = fed;
    for (int p = 0; p < 4; p++) begin
      src_idle  = phase_idle[p];
      dst_stall = phase_stall[p];
      while (fed < base + RANDOM_ITEMS * (p + 1) / 4) feed_stream();
    end

    // Halt the lexer for good, then show it stays silent
    src_idle  = 11;
    dst_stall = 11;
    case ($urandom_range(2))
      0: begin
        do b = 8'($urandom);
        while (b inside {[CH_TAB:CH_CR], CH_SPACE, [8'h61:8'h7A], [8'h41:8'h5A], 8'h5F,
                         [8'h30:8'h39], CH_SLASH, CH_QUOTE, CH_EQUAL, CH_BANG, CH_LESS,
                         CH_GREAT, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_SEMI,
                         CH_COMMA, CH_PLUS, CH_MINUS, CH_STAR});
        feed(b, 1'b0);
      end
      1: begin
        feed(CH_BANG, 1'b0);
        do b = 8'($urandom); while (b == CH_EQUAL);
        feed(b, 1'b0);
      end
      default: begin
        feed(CH_BANG, 1'b0);
        feed(8'($urandom), 1'b1);
      end
    endcase
    repeat (3) feed(8'($urandom), 1'b0);
    feed(8'($urandom), 1'b1);
    feed(CH_LPAREN, 1'b0);
    s_tvalid <= 1'b0;

    // Drain, then allow late stray results to show up
    while (due_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
